// ===== rtl/core/rida_pkg.sv =====
// Package for the ring identifier arithmetic unit: command codes, field widths, result type.
package rida_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned ID_W    = 2 * HALF_W;
    localparam int unsigned TOP_W   = 7;
    localparam int unsigned ORDER_W = 2;

    localparam int unsigned S_DATA_W = 6 * HALF_W;  // 384 bits, already whole bytes
    localparam int unsigned M_DATA_W = 144;         // 138 used bits, padded to bytes
    localparam int unsigned M_USED_W = 2 * HALF_W + 1 + ORDER_W + TOP_W;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MID  = 3'd2,
        CMD_DIST = 3'd3,
        CMD_ARC  = 3'd4,
        CMD_CMP  = 3'd5,
        CMD_LOG2 = 3'd6
    } cmd_t;

    localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

    typedef struct packed {
        logic [HALF_W-1:0]  res_hi;
        logic [HALF_W-1:0]  res_lo;
        logic               in_arc;
        logic [ORDER_W-1:0] order;
        logic [TOP_W-1:0]   top_bit;
    } result_t;

endpackage

// ===== rtl/core/ring_id_arithmetic_unit.sv =====
// Top level of the ring identifier arithmetic unit: two-stage stream pipeline.
//
// Usage: 128-bit identifiers on a ring modulo 2^128 enter on the slave stream
// (s_tvalid/s_tready/s_tdata/s_tuser). s_tuser carries the command: add,
// subtract, ring midpoint, ring distance, half-open arc test, three-way
// compare or highest set bit. Every accepted word gives exactly one result
// word on the master stream (m_tvalid/m_tready/m_tdata). Fields that do not
// belong to the command read as zero; command code 7 gives an all-zero word.
// Path: an accepted word passes the input register, then the result
// register, before it is offered on m_tvalid. Throughput: one word per
// cycle while m_tready is high; the single combinational pass of
// 128-bit adders, comparators and the priority encoder lies between
// the two registers.
// Stall: when m_tready is low the result register holds its word and the
// input register fills; s_tready drops only when both stages are full, and
// a new word is taken in the same cycle a result leaves.
// Reset: rst_n clears both stage valid flags asynchronously; no word is
// offered until one has been accepted after reset.
module ring_id_arithmetic_unit
    import rida_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata from bit 0 up: a_hi[63:0], a_lo[127:64], b_hi[191:128],
    // b_lo[255:192], x_hi[319:256], x_lo[383:320]
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: cmd[2:0]
    input  logic [2:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata from bit 0 up: res_hi[63:0], res_lo[127:64], in_arc[128],
    // order[130:129], top_bit[137:131], zero pad[143:138]
    output logic [M_DATA_W-1:0] m_tdata
);

    // Stage 1: input register
    logic                in_valid_reg;
    logic [2:0]          cmd_reg;
    logic [ID_W-1:0]     a_reg;
    logic [ID_W-1:0]     b_reg;
    logic [ID_W-1:0]     x_reg;

    // Stage 2: result register
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             out_next;

    logic                out_load;
    logic                in_load;

    // Advance the result stage when it is empty or its word is taken.
    assign out_load = !out_valid_reg || m_tready;
    // Take a new word when the input stage is empty or moves on.
    assign in_load  = !in_valid_reg || out_load;
    assign s_tready = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && s_tvalid)
        begin
            cmd_reg <= s_tuser;
            a_reg   <= {s_tdata[63:0],    s_tdata[127:64]};
            b_reg   <= {s_tdata[191:128], s_tdata[255:192]};
            x_reg   <= {s_tdata[319:256], s_tdata[383:320]};
        end
        if (out_load && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    // Single combinational pass over the registered operands.
    logic [ID_W-1:0]  sum_ab;
    logic [ID_W-1:0]  diff_ab;
    logic [ID_W-1:0]  mid_ab;
    logic [ID_W-1:0]  diff_xa;
    logic [ID_W-1:0]  diff_ax;
    logic [ID_W-1:0]  dist_sel;
    logic [ID_W-1:0]  dist_xa;
    logic             b_lt_a;
    logic             a_lt_b;
    logic             x_lt_a;
    logic             x_lt_b;
    logic             arc_hit;
    logic [TOP_W-1:0] top_idx;

    always_comb
    begin
        sum_ab  = a_reg + b_reg;
        diff_ab = a_reg - b_reg;
        diff_xa = x_reg - a_reg;
        diff_ax = a_reg - x_reg;
        b_lt_a  = b_reg < a_reg;
        a_lt_b  = a_reg < b_reg;
        x_lt_a  = x_reg < a_reg;
        x_lt_b  = x_reg < b_reg;

        // Halves summed with the shared low bit as carry-in; the half-turn
        // for a wrapped pair is a flip of the top bit.
        mid_ab = {1'b0, a_reg[ID_W-1:1]} + {1'b0, b_reg[ID_W-1:1]}
                 + {{(ID_W-1){1'b0}}, a_reg[0] & b_reg[0]};
        mid_ab[ID_W-1] = mid_ab[ID_W-1] ^ b_lt_a;

        // Longer way round is the negated difference, which is the other one.
        dist_sel = x_lt_a ? diff_ax : diff_xa;
        dist_xa  = dist_sel[ID_W-1] ? (x_lt_a ? diff_xa : diff_ax) : dist_sel;

        if (a_lt_b)
        begin
            arc_hit = !x_lt_a && x_lt_b;
        end
        else if (b_lt_a)
        begin
            arc_hit = !x_lt_a || x_lt_b;
        end
        else
        begin
            arc_hit = 1'b0;  // empty arc
        end

        // Priority encoder: highest set bit wins, zero subject reads as 0.
        top_idx = '0;
        for (int i = 0; i < ID_W; i++)
        begin
            if (x_reg[i])
            begin
                top_idx = TOP_W'(i);
            end
        end

        out_next = '0;
        unique case (cmd_reg)
            CMD_ADD:  {out_next.res_hi, out_next.res_lo} = sum_ab;
            CMD_SUB:  {out_next.res_hi, out_next.res_lo} = diff_ab;
            CMD_MID:  {out_next.res_hi, out_next.res_lo} = mid_ab;
            CMD_DIST: {out_next.res_hi, out_next.res_lo} = dist_xa;
            CMD_ARC:  out_next.in_arc = arc_hit;
            CMD_CMP:  out_next.order = a_lt_b ? ORDER_LESS :
                                       (b_lt_a ? ORDER_GREATER : ORDER_EQUAL);
            CMD_LOG2: out_next.top_bit = top_idx;
            default:  out_next = '0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-M_USED_W){1'b0}}, out_reg.top_bit, out_reg.order,
                       out_reg.in_arc, out_reg.res_lo, out_reg.res_hi};

    // A word accepted on the input lands in the input stage.
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted word did not reach the input stage");

    // A full input stage moves into a free result stage.
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("input stage word lost on the way to the result stage");

    // A blocked input stage holds its operands.
    a_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(a_reg) && $stable(cmd_reg))
        else $error("input stage changed while blocked");

    // The compare code never takes the unused value.
    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.order != 2'd3)
        else $error("compare result out of range");

    // When in_arc or order is nonzero, res_hi, res_lo and top_bit are zero.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_reg.in_arc || out_reg.order != '0)
        |-> out_reg.res_hi == '0 && out_reg.res_lo == '0 && out_reg.top_bit == '0)
        else $error("mixed result kinds in one word");

endmodule
